// ===== design/nge_pkg.sv =====
// Package for the next greater element block: sizes and the sequencer state type.
`default_nettype none
package nge_pkg;

    localparam int NGE_STACK_DEPTH = 32;
    localparam int NGE_DATA_W      = 32;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CMP   = 6'b000010,
        S_PUSH  = 6'b000100,
        S_FREAD = 6'b001000,
        S_FLUSH = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

endpackage
`default_nettype wire

// ===== design/next_greater_element.sv =====
// Next greater element finder: monotonic stack held in a one-port-read synchronous memory.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  input   | in        | i_valid / o_ready  | i_value, i_last
//  result  | out       | o_valid / i_ready  | o_element, o_next_value, o_has_next,
//          |           |                    | o_overflow, o_end_of_run
//
// One request at a time. Each request loops reading the stack top from memory through
// the registered read port and comparing, popping while its value is greater; it then
// pushes or flags overflow, then flushes the stack on last. Each result is held one
// slot back so end_of_run can be marked on the final one. Reset is synchronous and only
// clears the sequencer, stack count and valid flags; memory contents stay undefined. A
// stalled result channel stalls the sequencer wherever a new result must be queued.
`default_nettype none
module next_greater_element
    import nge_pkg::*;
#(
    parameter int STACK_DEPTH = NGE_STACK_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [NGE_DATA_W-1:0]  i_value,
    input  wire logic                          i_last,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [NGE_DATA_W-1:0]       o_element,
    output logic signed [NGE_DATA_W-1:0]       o_next_value,
    output logic                               o_has_next,
    output logic                               o_overflow,
    output logic                               o_end_of_run
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [CW-1:0] TWO_C   = CW'(2);

    // stack memory and its registered read port
    logic [NGE_DATA_W-1:0] mem [STACK_DEPTH];
    logic signed [NGE_DATA_W-1:0] r_rdata;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;

    // sequencer and request registers
    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic signed [NGE_DATA_W-1:0] r_val;
    logic r_last;
    logic r_popped, n_popped;

    // held result, one slot behind the output register
    logic r_hold_v, n_hold_v;
    logic signed [NGE_DATA_W-1:0] r_hold_elem, n_hold_elem;
    logic signed [NGE_DATA_W-1:0] r_hold_next, n_hold_next;
    logic r_hold_has, n_hold_has;
    logic r_hold_ovf, n_hold_ovf;

    // output register
    logic r_o_valid, n_o_valid;
    logic signed [NGE_DATA_W-1:0] r_o_elem, n_o_elem;
    logic signed [NGE_DATA_W-1:0] r_o_next, n_o_next;
    logic r_o_has, n_o_has;
    logic r_o_ovf, n_o_ovf;
    logic r_o_end, n_o_end;

    // new result request from the sequencer
    logic em_req;
    logic signed [NGE_DATA_W-1:0] em_elem;
    logic signed [NGE_DATA_W-1:0] em_next;
    logic em_has;
    logic em_ovf;
    logic fin_req;

    logic out_free;
    logic can_emit;
    logic accept;

    assign out_free = !r_o_valid || i_ready;
    assign can_emit = !r_hold_v || out_free;
    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_popped = r_popped;
        rd_en    = 1'b0;
        rd_addr  = AW'(r_count - ONE_C);
        wr_en    = 1'b0;
        wr_addr  = AW'(r_count);
        em_req   = 1'b0;
        em_elem  = r_rdata;
        em_next  = '0;
        em_has   = 1'b0;
        em_ovf   = 1'b0;
        fin_req  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_popped = 1'b0;
                    if (r_count != '0) begin
                        rd_en   = 1'b1;
                        n_state = S_CMP;
                    end else begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_CMP: begin
                if (r_val > r_rdata) begin
                    em_req  = 1'b1;
                    em_next = r_val;
                    em_has  = 1'b1;
                    if (can_emit) begin
                        n_count  = r_count - ONE_C;
                        n_popped = 1'b1;
                        if (r_count != ONE_C) begin
                            rd_en   = 1'b1;
                            rd_addr = AW'(r_count - TWO_C);
                        end else begin
                            n_state = S_PUSH;
                        end
                    end
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (r_count < DEPTH_C) begin
                    wr_en   = 1'b1;
                    n_count = r_count + ONE_C;
                    n_state = r_last ? S_FREAD : S_FIN;
                end else if (!r_popped) begin
                    em_req  = 1'b1;
                    em_elem = r_val;
                    em_ovf  = 1'b1;
                    if (can_emit) begin
                        n_state = r_last ? S_FREAD : S_FIN;
                    end
                end else begin
                    n_state = r_last ? S_FREAD : S_FIN;
                end
            end
            S_FREAD: begin
                if (r_count != '0) begin
                    rd_en   = 1'b1;
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FLUSH: begin
                em_req = 1'b1;
                if (can_emit) begin
                    n_count = r_count - ONE_C;
                    if (r_count != ONE_C) begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(r_count - TWO_C);
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                fin_req = 1'b1;
                if (!r_hold_v || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result queue: hold slot feeds the output register
    always_comb begin
        n_hold_v    = r_hold_v;
        n_hold_elem = r_hold_elem;
        n_hold_next = r_hold_next;
        n_hold_has  = r_hold_has;
        n_hold_ovf  = r_hold_ovf;
        n_o_valid   = r_o_valid && !i_ready;
        n_o_elem    = r_o_elem;
        n_o_next    = r_o_next;
        n_o_has     = r_o_has;
        n_o_ovf     = r_o_ovf;
        n_o_end     = r_o_end;
        if (em_req && can_emit) begin
            if (r_hold_v) begin
                n_o_valid = 1'b1;
                n_o_elem  = r_hold_elem;
                n_o_next  = r_hold_next;
                n_o_has   = r_hold_has;
                n_o_ovf   = r_hold_ovf;
                n_o_end   = 1'b0;
            end
            n_hold_v    = 1'b1;
            n_hold_elem = em_elem;
            n_hold_next = em_next;
            n_hold_has  = em_has;
            n_hold_ovf  = em_ovf;
        end else if (fin_req && r_hold_v && out_free) begin
            n_o_valid = 1'b1;
            n_o_elem  = r_hold_elem;
            n_o_next  = r_hold_next;
            n_o_has   = r_hold_has;
            n_o_ovf   = r_hold_ovf;
            n_o_end   = 1'b1;
            n_hold_v  = 1'b0;
        end
    end

    // stack memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_val;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_popped  <= 1'b0;
            r_hold_v  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_popped  <= n_popped;
            r_hold_v  <= n_hold_v;
            r_o_valid <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_val  <= i_value;
            r_last <= i_last;
        end
        r_hold_elem <= n_hold_elem;
        r_hold_next <= n_hold_next;
        r_hold_has  <= n_hold_has;
        r_hold_ovf  <= n_hold_ovf;
        r_o_elem    <= n_o_elem;
        r_o_next    <= n_o_next;
        r_o_has     <= n_o_has;
        r_o_ovf     <= n_o_ovf;
        r_o_end     <= n_o_end;
    end

    assign o_valid      = r_o_valid;
    assign o_element    = r_o_elem;
    assign o_next_value = r_o_next;
    assign o_has_next   = r_o_has;
    assign o_overflow   = r_o_ovf;
    assign o_end_of_run = r_o_end;

endmodule
`default_nettype wire
